// File: rtl/caldc_pkg.sv
// Shared types, constants and a calendar function for the calendar date counter.
package caldc_pkg;

  localparam logic FUNC_SET = 1'b0;
  localparam logic FUNC_ADV = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MONTH = 3'd1;
  localparam logic [2:0] ST_BAD_YEAR  = 3'd2;
  localparam logic [2:0] ST_BAD_DAY   = 3'd3;
  localparam logic [2:0] ST_LIMIT     = 3'd4;

  localparam logic [11:0] YEAR_RESET   = 12'd1900;
  localparam logic [11:0] YEAR_MIN_SET = 12'd1900;
  localparam logic [11:0] YEAR_MID_SET = 12'd2000;
  localparam logic [11:0] YEAR_MAX_SET = 12'd2100;
  localparam logic [11:0] YEAR_LIMIT   = 12'd4095;

  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [4:0] FEB_LEAP  = 5'd29;

  // century index mod 4 for the years the set path can load
  localparam logic [1:0] CENT_1900 = 2'd3;
  localparam logic [1:0] CENT_2000 = 2'd0;
  localparam logic [1:0] CENT_2100 = 2'd1;
  localparam logic [6:0] LAST_YY   = 7'd99;

  // month 0 and codes above 12 read as 31 days
  localparam logic [4:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic        func;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [11:0] set_year;
    logic [15:0] day_count;
  } item_t;

  typedef struct packed {
    logic accept;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic first_done;
    logic run_done;
  } sts_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    if (m == MONTH_FEB && leap) begin
      return FEB_LEAP;
    end
    return MONTH_LEN[m];
  endfunction

endpackage

// File: rtl/caldc_if.sv
// Word channels of the calendar date counter: request and response.
interface caldc_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  set_month;
  logic [4:0]  set_day;
  logic [11:0] set_year;
  logic [15:0] day_count;

  modport source (output valid, func, set_month, set_day, set_year, day_count,
                  input ready);
  modport sink (input valid, func, set_month, set_day, set_year, day_count,
                output ready);
endinterface

interface caldc_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [11:0] year;
  logic [3:0]  prev_month;
  logic [4:0]  prev_day;
  logic [11:0] prev_year;
  logic [2:0]  status;

  modport source (output valid, month, day, year, prev_month, prev_day, prev_year,
                  status, input ready);
  modport sink (input valid, month, day, year, prev_month, prev_day, prev_year,
                status, output ready);
endinterface

// File: rtl/caldc_dpath.sv
// Datapath: date registers, set checks, one-day stepper and remaining count.
module caldc_dpath
  import caldc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  item_t       item,
  output sts_t        sts,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [11:0] year,
  output logic [3:0]  prev_month,
  output logic [4:0]  prev_day,
  output logic [11:0] prev_year,
  output logic [2:0]  status
);

  logic [6:0]  yy;        // year mod 100
  logic [1:0]  cent;      // century mod 4
  logic [15:0] rem;

  logic        leap_cur;
  logic [4:0]  len_cur;
  logic        month_end;
  logic        blocked;
  logic        do_step;

  logic        leap_set;
  logic [2:0]  set_status;
  logic [6:0]  set_yy;
  logic [1:0]  set_cent;
  logic [11:0] year_off;

  assign leap_cur  = (yy[1:0] == 2'd0) && ((yy != 7'd0) || (cent == 2'd0));
  assign len_cur   = days_in(month, leap_cur);
  assign month_end = (day >= len_cur);
  assign blocked   = month_end && (month >= MONTH_DEC) && (year == YEAR_LIMIT);
  assign do_step   = cmd.step ||
                     (cmd.accept && item.func == FUNC_ADV && item.day_count != 16'd0);

  assign leap_set = (item.set_year[1:0] == 2'd0) && (item.set_year != YEAR_MIN_SET) &&
                    (item.set_year != YEAR_MAX_SET);

  always_comb begin
    if (item.set_month == 4'd0 || item.set_month > MONTH_DEC) begin
      set_status = ST_BAD_MONTH;
    end else if (item.set_year < YEAR_MIN_SET || item.set_year > YEAR_MAX_SET) begin
      set_status = ST_BAD_YEAR;
    end else if (item.set_day == 5'd0 ||
                 item.set_day > days_in(item.set_month, leap_set)) begin
      set_status = ST_BAD_DAY;
    end else begin
      set_status = ST_OK;
    end
  end

  always_comb begin
    if (item.set_year >= YEAR_MAX_SET) begin
      year_off = item.set_year - YEAR_MAX_SET;
      set_cent = CENT_2100;
    end else if (item.set_year >= YEAR_MID_SET) begin
      year_off = item.set_year - YEAR_MID_SET;
      set_cent = CENT_2000;
    end else begin
      year_off = item.set_year - YEAR_MIN_SET;
      set_cent = CENT_1900;
    end
    set_yy = year_off[6:0];
  end

  assign sts.first_done = (item.func == FUNC_SET) || (item.day_count <= 16'd1) || blocked;
  assign sts.run_done   = (rem == 16'd1) || blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      month <= 4'd1;
      day   <= 5'd1;
      year  <= YEAR_RESET;
      yy    <= 7'd0;
      cent  <= CENT_1900;
    end else if (cmd.accept && item.func == FUNC_SET) begin
      if (set_status == ST_OK) begin
        month <= item.set_month;
        day   <= item.set_day;
        year  <= item.set_year;
        yy    <= set_yy;
        cent  <= set_cent;
      end
    end else if (do_step && !blocked) begin
      if (!month_end) begin
        day <= day + 5'd1;
      end else if (month < MONTH_DEC) begin
        month <= month + 4'd1;
        day   <= 5'd1;
      end else begin
        year  <= year + 12'd1;
        month <= 4'd1;
        day   <= 5'd1;
        if (yy == LAST_YY) begin
          yy   <= 7'd0;
          cent <= cent + 2'd1;
        end else begin
          yy <= yy + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      prev_month <= month;
      prev_day   <= day;
      prev_year  <= year;
      rem        <= item.day_count - 16'd1;
      if (item.func == FUNC_SET) begin
        status <= set_status;
      end else if (do_step && blocked) begin
        status <= ST_LIMIT;
      end else begin
        status <= ST_OK;
      end
    end else if (cmd.step) begin
      rem <= rem - 16'd1;
      if (blocked) begin
        status <= ST_LIMIT;
      end
    end
  end

endmodule

// File: rtl/caldc_ctrl.sv
// Controller: handshake, advance sequencing and result word valid.
module caldc_ctrl
  import caldc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic rsp_valid_next;
  logic acc;

  assign req_ready  = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign acc        = req_valid && req_ready;
  assign cmd.accept = acc;
  assign cmd.step   = (state == S_RUN);

  always_comb begin
    state_next     = state;
    rsp_valid_next = rsp_valid;
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (acc) begin
          if (sts.first_done) begin
            rsp_valid_next = 1'b1;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (sts.run_done) begin
          state_next     = S_IDLE;
          rsp_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// File: rtl/calendar_date_counter_unit.sv
// Top level of the calendar date counter.
// Usage:
//   req carries one word per item: func 0 sets the date from set_month,
//   set_day and set_year after checking it; func 1 advances by day_count days.
//   rsp returns one word per item: the date after the item, the date before
//   it and a status code (ok, bad month, bad year, bad day, year limit).
// Sequencing:
//   A set, an advance by 0 or 1 day, or an advance blocked at 31 Dec 4095,
//   completes in the accept cycle; the response word is valid next cycle.
//   An advance by N days runs the one-day stepper once per cycle until N days
//   are stepped or 31 Dec 4095 is reached; no new request is taken meanwhile.
//   A new request is taken in the cycle its predecessor's response leaves.
// Reset:
//   rst clears the date to 1 Jan 1900 and drops any pending response.
// Stall:
//   While rsp is held off the response word stays stable and req.ready is low.
module calendar_date_counter_unit
  import caldc_pkg::*;
(
  input logic          clk,
  input logic          rst,
  caldc_req_if.sink    req,
  caldc_rsp_if.source  rsp
);

  item_t item;
  cmd_t  cmd;
  sts_t  sts;

  assign item.func      = req.func;
  assign item.set_month = req.set_month;
  assign item.set_day   = req.set_day;
  assign item.set_year  = req.set_year;
  assign item.day_count = req.day_count;

  caldc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  caldc_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item       (item),
    .sts        (sts),
    .month      (rsp.month),
    .day        (rsp.day),
    .year       (rsp.year),
    .prev_month (rsp.prev_month),
    .prev_day   (rsp.prev_day),
    .prev_year  (rsp.prev_year),
    .status     (rsp.status)
  );

endmodule

// File: tb/sv/tb_calendar_date_counter_unit.sv
`timescale 1ns / 100ps
// Testbench for the calendar date counter: directed and random words checked against a date model.
module tb_calendar_date_counter_unit;
  import caldc_pkg::*;

  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [11:0] year;
    logic [3:0]  prev_month;
    logic [4:0]  prev_day;
    logic [11:0] prev_year;
    logic [2:0]  status;
  } date_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  caldc_req_if req_ch ();
  caldc_rsp_if rsp_ch ();

  calendar_date_counter_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #10 clk = ~clk;

  date_rsp_t  date_q [$];
  int         cal_month = 1;
  int         cal_day   = 1;
  int         cal_year  = 1900;
  logic [2:0] last_status;
  bit         src_calm;
  bit         rx_calm;
  int         n_loads;
  int         n_rejects;
  int         n_advances;
  int         n_days;
  int         n_limits;
  int         n_checked;
  int         n_errors;

  function automatic bit leap_year(input int y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int month_days(input int m, input int y);
    case (m)
      2: begin
        return leap_year(y) ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // works out the response word for one accepted word and moves the date on
  task automatic predict_date(input item_t w, output date_rsp_t r);
    int m;
    int d;
    int y;
    int left;
    r.prev_month = 4'(cal_month);
    r.prev_day   = 5'(cal_day);
    r.prev_year  = 12'(cal_year);
    r.status     = ST_OK;
    if (w.func == FUNC_SET) begin
      m = int'(w.set_month);
      d = int'(w.set_day);
      y = int'(w.set_year);
      if (m < 1 || m > MONTH_DEC) begin
        r.status = ST_BAD_MONTH;
      end else if (y < YEAR_MIN_SET || y > YEAR_MAX_SET) begin
        r.status = ST_BAD_YEAR;
      end else if (d < 1 || d > month_days(m, y)) begin
        r.status = ST_BAD_DAY;
      end else begin
        cal_month = m;
        cal_day   = d;
        cal_year  = y;
      end
      if (r.status == ST_OK) begin
        n_loads++;
      end else begin
        n_rejects++;
      end
    end else begin
      n_advances++;
      for (left = int'(w.day_count); left > 0 && r.status == ST_OK; left--) begin
        if (cal_day < month_days(cal_month, cal_year)) begin
          cal_day++;
          n_days++;
        end else if (cal_month < MONTH_DEC) begin
          cal_month++;
          cal_day = 1;
          n_days++;
        end else if (cal_year >= YEAR_LIMIT) begin
          r.status = ST_LIMIT;
          n_limits++;
        end else begin
          cal_year++;
          cal_month = 1;
          cal_day   = 1;
          n_days++;
        end
      end
    end
    r.month     = 4'(cal_month);
    r.day       = 5'(cal_day);
    r.year      = 12'(cal_year);
    last_status = r.status;
  endtask

  function automatic item_t set_word(input int m, input int d, input int y);
    item_t w;
    w.func      = FUNC_SET;
    w.set_month = 4'(m);
    w.set_day   = 5'(d);
    w.set_year  = 12'(y);
    w.day_count = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic item_t adv_word(input int n);
    item_t w;
    w.func      = FUNC_ADV;
    w.set_month = 4'($urandom_range(0, 15));
    w.set_day   = 5'($urandom_range(0, 31));
    w.set_year  = 12'($urandom_range(0, 4095));
    w.day_count = 16'(n);
    return w;
  endfunction

  // valid stays high into the next word when no gap is drawn
  task automatic send_word(input item_t w);
    int gap;
    date_rsp_t e;
    gap = src_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= w.func;
    req_ch.set_month <= w.set_month;
    req_ch.set_day   <= w.set_day;
    req_ch.set_year  <= w.set_year;
    req_ch.day_count <= w.day_count;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_date(w, e);
    date_q.push_back(e);
  endtask

  task automatic check_field(input string name, input logic [11:0] e, input logic [11:0] a);
    if (a !== e) begin
      $display("%0t: %s expected %0d got %0d", $time, name, e, a);
      n_errors++;
    end
  endtask

  initial begin
    int stall;
    date_rsp_t e;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      n_checked++;
      if (date_q.size() == 0) begin
        $display("%0t: response word with none expected: %0d/%0d/%0d status %0d", $time,
                 rsp_ch.month, rsp_ch.day, rsp_ch.year, rsp_ch.status);
        n_errors++;
      end else begin
        e = date_q.pop_front();
        check_field("month", 12'(e.month), 12'(rsp_ch.month));
        check_field("day", 12'(e.day), 12'(rsp_ch.day));
        check_field("year", e.year, rsp_ch.year);
        check_field("prev_month", 12'(e.prev_month), 12'(rsp_ch.prev_month));
        check_field("prev_day", 12'(e.prev_day), 12'(rsp_ch.prev_day));
        check_field("prev_year", e.prev_year, rsp_ch.prev_year);
        check_field("status", 12'(e.status), 12'(rsp_ch.status));
      end
    end
  end

  task automatic test_reset_state();
    send_word(adv_word(0));
    send_word(adv_word(1));
  endtask

  // invalid loads in every check order, and the boundaries that pass
  task automatic test_set_checks();
    send_word(set_word(int'(MONTH_FEB), 29, 2000));
    send_word(set_word(0, 15, 2000));
    send_word(set_word(15, 31, 4095));
    send_word(set_word(13, 1, 1950));
    send_word(set_word(6, 10, 1899));
    send_word(set_word(6, 10, 2101));
    send_word(set_word(7, 0, 0));
    send_word(set_word(4, 31, 2020));
    send_word(set_word(int'(MONTH_FEB), 29, 1900));
    send_word(set_word(int'(MONTH_FEB), 29, 2100));
    send_word(set_word(int'(MONTH_FEB), 30, 2004));
    send_word(set_word(1, 1, int'(YEAR_MIN_SET)));
    send_word(set_word(int'(MONTH_DEC), 31, int'(YEAR_MAX_SET)));
  endtask

  task automatic test_day_rollover();
    send_word(set_word(1, 31, 2001));
    send_word(adv_word(1));
    send_word(set_word(int'(MONTH_FEB), 28, 2004));
    send_word(adv_word(2));
    send_word(set_word(int'(MONTH_FEB), 28, 2100));
    send_word(adv_word(1));
    send_word(set_word(int'(MONTH_DEC), 31, 1999));
    send_word(adv_word(367));
  endtask

  task automatic test_year_limit();
    int guard;
    send_word(set_word(int'(MONTH_DEC), 31, int'(YEAR_MAX_SET)));
    guard = 0;
    do begin
      send_word(adv_word(65535));
      guard++;
    end while (last_status != ST_LIMIT && guard < 20);
    send_word(adv_word(1));
    send_word(adv_word(0));
    send_word(set_word(int'(MONTH_FEB), 29, 2096));
  endtask

  task automatic test_random_mix(input int n_words);
    int i;
    int pick;
    int m;
    int y;
    int len;
    int cnt;
    for (i = 0; i < n_words; i++) begin
      if (i % 150 == 0) begin
        src_calm = ($urandom_range(0, 3) == 0);
        rx_calm  = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        m = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0: y = int'(YEAR_MIN_SET);
          1: y = int'(YEAR_MID_SET);
          2: y = int'(YEAR_MAX_SET);
          default: y = $urandom_range(YEAR_MIN_SET, YEAR_MAX_SET);
        endcase
        if ($urandom_range(0, 1) == 0) begin
          y = $urandom_range(YEAR_MIN_SET, YEAR_MAX_SET);
        end
        len = month_days(m, y);
        if ($urandom_range(0, 1) == 0) begin
          send_word(set_word(m, $urandom_range(len - 2, len), y));
        end else begin
          send_word(set_word(m, $urandom_range(1, len), y));
        end
      end else if (pick < 50) begin
        send_word(set_word($urandom_range(0, 15), $urandom_range(0, 31),
                           $urandom_range(0, 4095)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          cnt = $urandom_range(0, 2);
        end else if (pick < 80) begin
          cnt = $urandom_range(3, 40);
        end else if (pick < 95) begin
          cnt = $urandom_range(41, 400);
        end else begin
          cnt = $urandom_range(401, 2000);
        end
        send_word(adv_word(cnt));
      end
    end
    src_calm = 1'b0;
    rx_calm  = 1'b0;
  endtask

  task automatic finish_run();
    req_ch.valid <= 1'b0;
    while (date_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Loads %0d, rejected loads %0d, advances %0d over %0d days, year-limit stops %0d",
             n_loads, n_rejects, n_advances, n_days, n_limits);
    $display("Response words checked %0d, mismatches %0d", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  endtask

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FUNC_SET;
    req_ch.set_month <= '0;
    req_ch.set_day   <= '0;
    req_ch.set_year  <= '0;
    req_ch.day_count <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_set_checks();
    test_day_rollover();
    test_year_limit();
    test_random_mix(1500);
    finish_run();
  end

  initial begin
    #(400_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
